/* hw/rtl/swle_pkg.sv */
// ============================================================================
// swle_pkg
// Shared widths, constants and control types of the loss estimator.
// ============================================================================
package swle_pkg;

    localparam int DATA_W     = 32;
    localparam int RATE_W     = 17;
    localparam int FILL_OUT_W = 6;
    localparam int CFG_IDX_W  = 1;

    localparam logic [RATE_W-1:0] Q_ONE = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LOSS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LOSS = 1'b1;

    typedef struct packed {
        logic load_new;
        logic load_old;
        logic step;
    } sum_ctrl_t;

endpackage

/* hw/rtl/swle_ring.sv */
// ============================================================================
// swle_ring
// Report ring: seen/sent memories, write slot, fill level, evicted word.
// ============================================================================
module swle_ring #(
    parameter int WINDOW_BINS = 32,
    parameter int SLOT_W      = 5,
    parameter int FILL_W      = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [swle_pkg::DATA_W-1:0] seen,
    input  logic [swle_pkg::DATA_W-1:0] sent,
    output logic [swle_pkg::DATA_W-1:0] old_seen,
    output logic [swle_pkg::DATA_W-1:0] old_sent,
    output logic [FILL_W-1:0]           fill
);

    logic [swle_pkg::DATA_W-1:0] mem_seen [WINDOW_BINS];
    logic [swle_pkg::DATA_W-1:0] mem_sent [WINDOW_BINS];

    logic [swle_pkg::DATA_W-1:0] rd_seen_reg;
    logic [swle_pkg::DATA_W-1:0] rd_sent_reg;
    logic                        was_full_reg;
    logic [SLOT_W-1:0]           slot_reg;
    logic [SLOT_W-1:0]           slot_next;
    logic [FILL_W-1:0]           fill_reg;
    logic [FILL_W-1:0]           fill_next;
    logic                        full;

    assign full = (fill_reg == FILL_W'(WINDOW_BINS));

    always_comb
    begin
        slot_next = slot_reg;
        fill_next = fill_reg;
        if (push)
        begin
            if (slot_reg == SLOT_W'(WINDOW_BINS - 1))
                slot_next = '0;
            else
                slot_next = slot_reg + 1'b1;
            if (!full)
                fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            fill_reg     <= '0;
            was_full_reg <= 1'b0;
        end
        else
        begin
            slot_reg <= slot_next;
            fill_reg <= fill_next;
            if (push)
                was_full_reg <= full;
        end
    end

    // read-first: the evicted word comes out as the new one goes in
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            rd_seen_reg        <= mem_seen[slot_reg];
            rd_sent_reg        <= mem_sent[slot_reg];
            mem_seen[slot_reg] <= seen;
            mem_sent[slot_reg] <= sent;
        end
    end

    assign old_seen = rd_seen_reg & {swle_pkg::DATA_W{was_full_reg}};
    assign old_sent = rd_sent_reg & {swle_pkg::DATA_W{was_full_reg}};
    assign fill     = fill_reg;

endmodule

/* hw/rtl/swle_serial_sum.sv */
// ============================================================================
// swle_serial_sum
// Bit-serial window sums: total += new - old, and lost = sent - seen, LSB first.
// ============================================================================
module swle_serial_sum #(
    parameter int SUM_W = 37
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  swle_pkg::sum_ctrl_t         ctrl,
    input  logic [swle_pkg::DATA_W-1:0] new_seen,
    input  logic [swle_pkg::DATA_W-1:0] new_sent,
    input  logic [swle_pkg::DATA_W-1:0] old_seen,
    input  logic [swle_pkg::DATA_W-1:0] old_sent,
    output logic [SUM_W-1:0]            total_sent,
    output logic [SUM_W-1:0]            lost
);

    logic [SUM_W-1:0] tot_seen_reg;
    logic [SUM_W-1:0] tot_sent_reg;
    logic [SUM_W-1:0] new_seen_sh;
    logic [SUM_W-1:0] new_sent_sh;
    logic [SUM_W-1:0] old_seen_sh;
    logic [SUM_W-1:0] old_sent_sh;
    logic [SUM_W-1:0] lost_sh;
    logic             bor_seen_reg;
    logic             car_seen_reg;
    logic             bor_sent_reg;
    logic             car_sent_reg;
    logic             bor_lost_reg;

    logic d_seen;
    logic d_sent;
    logic s_seen;
    logic s_sent;
    logic l_bit;
    logic bor_seen_next;
    logic car_seen_next;
    logic bor_sent_next;
    logic car_sent_next;
    logic bor_lost_next;

    always_comb
    begin
        d_seen        = tot_seen_reg[0] ^ old_seen_sh[0] ^ bor_seen_reg;
        bor_seen_next = (~tot_seen_reg[0] & old_seen_sh[0])
                      | (~(tot_seen_reg[0] ^ old_seen_sh[0]) & bor_seen_reg);
        s_seen        = d_seen ^ new_seen_sh[0] ^ car_seen_reg;
        car_seen_next = (d_seen & new_seen_sh[0]) | (d_seen & car_seen_reg)
                      | (new_seen_sh[0] & car_seen_reg);

        d_sent        = tot_sent_reg[0] ^ old_sent_sh[0] ^ bor_sent_reg;
        bor_sent_next = (~tot_sent_reg[0] & old_sent_sh[0])
                      | (~(tot_sent_reg[0] ^ old_sent_sh[0]) & bor_sent_reg);
        s_sent        = d_sent ^ new_sent_sh[0] ^ car_sent_reg;
        car_sent_next = (d_sent & new_sent_sh[0]) | (d_sent & car_sent_reg)
                      | (new_sent_sh[0] & car_sent_reg);

        l_bit         = s_sent ^ s_seen ^ bor_lost_reg;
        bor_lost_next = (~s_sent & s_seen) | (~(s_sent ^ s_seen) & bor_lost_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tot_seen_reg <= '0;
            tot_sent_reg <= '0;
            bor_seen_reg <= 1'b0;
            car_seen_reg <= 1'b0;
            bor_sent_reg <= 1'b0;
            car_sent_reg <= 1'b0;
            bor_lost_reg <= 1'b0;
        end
        else if (ctrl.load_new)
        begin
            bor_seen_reg <= 1'b0;
            car_seen_reg <= 1'b0;
            bor_sent_reg <= 1'b0;
            car_sent_reg <= 1'b0;
            bor_lost_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            tot_seen_reg <= {s_seen, tot_seen_reg[SUM_W-1:1]};
            tot_sent_reg <= {s_sent, tot_sent_reg[SUM_W-1:1]};
            bor_seen_reg <= bor_seen_next;
            car_seen_reg <= car_seen_next;
            bor_sent_reg <= bor_sent_next;
            car_sent_reg <= car_sent_next;
            bor_lost_reg <= bor_lost_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_new)
        begin
            new_seen_sh <= SUM_W'(new_seen);
            new_sent_sh <= SUM_W'(new_sent);
        end
        else if (ctrl.step)
        begin
            new_seen_sh <= new_seen_sh >> 1;
            new_sent_sh <= new_sent_sh >> 1;
        end

        if (ctrl.load_old)
        begin
            old_seen_sh <= SUM_W'(old_seen);
            old_sent_sh <= SUM_W'(old_sent);
        end
        else if (ctrl.step)
        begin
            old_seen_sh <= old_seen_sh >> 1;
            old_sent_sh <= old_sent_sh >> 1;
        end

        if (ctrl.step)
            lost_sh <= {l_bit, lost_sh[SUM_W-1:1]};
    end

    assign total_sent = tot_sent_reg;
    assign lost       = lost_sh;

endmodule

/* hw/rtl/swle_divider.sv */
// ============================================================================
// swle_divider
// Restoring divider, one quotient bit per cycle: (lost << 16) / total_sent.
// ============================================================================
module swle_divider #(
    parameter int SUM_W = 37
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [SUM_W-1:0]            dividend,
    input  logic [SUM_W-1:0]            divisor,
    output logic                        done,
    output logic [swle_pkg::RATE_W-1:0] quotient
);

    localparam int CNT_W = $clog2(swle_pkg::RATE_W + 1);

    logic [SUM_W:0]                rem_reg;
    logic [SUM_W-1:0]              dvs_reg;
    logic [swle_pkg::RATE_W-1:0]   q_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          done_reg;

    logic [SUM_W+1:0] diff;
    logic             ge;
    logic [SUM_W:0]   rem_kept;

    always_comb
    begin
        diff     = {1'b0, rem_reg} - {2'b00, dvs_reg};
        ge       = ~diff[SUM_W+1];
        rem_kept = ge ? diff[SUM_W:0] : rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(swle_pkg::RATE_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, dividend};
            dvs_reg <= divisor;
            q_reg   <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= {rem_kept[SUM_W-1:0], 1'b0};
            q_reg   <= {q_reg[swle_pkg::RATE_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* hw/rtl/sliding_window_loss_estimator.sv */
// ============================================================================
// sliding_window_loss_estimator
// Stored report: fetch, bit-serial sum update, divider start and the 17-step
// divider, then the done state; a rejected report goes straight to done.
// One report in flight at a time; the output word register frees the input.
// Reset (rst_n, async, low) empties the window, clears rates, min 0, max 1.0.
// ============================================================================
module sliding_window_loss_estimator #(
    parameter int WINDOW_BINS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [swle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swle_pkg::RATE_W-1:0]    cfg_data,
    input  logic                           report_valid,
    output logic                           report_stall,
    input  logic [swle_pkg::DATA_W-1:0]    seen_packets,
    input  logic [swle_pkg::DATA_W-1:0]    sent_packets,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic                           accepted,
    output logic [swle_pkg::RATE_W-1:0]    raw_loss,
    output logic [swle_pkg::RATE_W-1:0]    limited_loss,
    output logic [swle_pkg::FILL_OUT_W-1:0] window_fill
);

    localparam int SLOT_W = (WINDOW_BINS > 1) ? $clog2(WINDOW_BINS) : 1;
    localparam int FILL_W = $clog2(WINDOW_BINS + 1);
    localparam int SUM_W  = swle_pkg::DATA_W + $clog2(WINDOW_BINS);
    localparam int CNT_W  = $clog2(SUM_W);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FETCH  = 3'd1;
    localparam logic [2:0] ST_SUM    = 3'd2;
    localparam logic [2:0] ST_DIV_GO = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            cnt_next;
    logic                        stored_reg;
    logic [swle_pkg::RATE_W-1:0] min_loss_reg;
    logic [swle_pkg::RATE_W-1:0] max_loss_reg;
    logic [swle_pkg::RATE_W-1:0] raw_rate_reg;
    logic [swle_pkg::RATE_W-1:0] limited_rate_reg;
    logic                        result_valid_reg;

    logic                          accepted_reg;
    logic [swle_pkg::RATE_W-1:0]   raw_loss_reg;
    logic [swle_pkg::RATE_W-1:0]   limited_loss_reg;
    logic [swle_pkg::FILL_OUT_W-1:0] window_fill_reg;

    logic                         take;
    logic                         ok;
    logic                         push;
    logic                         out_load;
    logic                         div_start;
    logic                         div_done;
    logic [swle_pkg::RATE_W-1:0]  quotient;
    logic [swle_pkg::RATE_W-1:0]  clamped;
    logic [swle_pkg::DATA_W-1:0]  old_seen;
    logic [swle_pkg::DATA_W-1:0]  old_sent;
    logic [FILL_W-1:0]            fill;
    logic [FILL_W+swle_pkg::FILL_OUT_W-1:0] fill_ext;
    logic [SUM_W-1:0]             total_sent;
    logic [SUM_W-1:0]             lost;
    swle_pkg::sum_ctrl_t          sum_ctrl;

    assign report_stall = (state_reg != ST_IDLE);
    assign take         = report_valid && !report_stall;
    assign ok           = (sent_packets != '0) && (seen_packets <= sent_packets);
    assign push         = take && ok;
    assign out_load     = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);
    assign div_start    = (state_reg == ST_DIV_GO);

    assign sum_ctrl.load_new = push;
    assign sum_ctrl.load_old = (state_reg == ST_FETCH);
    assign sum_ctrl.step     = (state_reg == ST_SUM);

    assign fill_ext = {{swle_pkg::FILL_OUT_W{1'b0}}, fill};

    always_comb
    begin
        if (quotient < min_loss_reg)
            clamped = min_loss_reg;
        else if (quotient > max_loss_reg)
            clamped = max_loss_reg;
        else
            clamped = quotient;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                    state_next = ok ? ST_FETCH : ST_DONE;
            end
            ST_FETCH:
            begin
                cnt_next   = '0;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SUM_W - 1))
                    state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            stored_reg       <= 1'b0;
            min_loss_reg     <= '0;
            max_loss_reg     <= swle_pkg::Q_ONE;
            raw_rate_reg     <= '0;
            limited_rate_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (take)
                stored_reg <= ok;
            if (cfg_write)
            begin
                case (cfg_index)
                    swle_pkg::REG_MIN_LOSS: min_loss_reg <= cfg_data;
                    swle_pkg::REG_MAX_LOSS: max_loss_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (div_done && state_reg == ST_DIV)
            begin
                raw_rate_reg     <= quotient;
                limited_rate_reg <= clamped;
            end
            if (out_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            accepted_reg     <= stored_reg;
            raw_loss_reg     <= raw_rate_reg;
            limited_loss_reg <= (fill == '0) ? min_loss_reg : limited_rate_reg;
            window_fill_reg  <= fill_ext[swle_pkg::FILL_OUT_W-1:0];
        end
    end

    assign result_valid   = result_valid_reg;
    assign accepted       = accepted_reg;
    assign raw_loss       = raw_loss_reg;
    assign limited_loss   = limited_loss_reg;
    assign window_fill    = window_fill_reg;

    swle_ring #(
        .WINDOW_BINS (WINDOW_BINS),
        .SLOT_W      (SLOT_W),
        .FILL_W      (FILL_W)
    ) u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .seen     (seen_packets),
        .sent     (sent_packets),
        .old_seen (old_seen),
        .old_sent (old_sent),
        .fill     (fill)
    );

    swle_serial_sum #(
        .SUM_W (SUM_W)
    ) u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (sum_ctrl),
        .new_seen   (seen_packets),
        .new_sent   (sent_packets),
        .old_seen   (old_seen),
        .old_sent   (old_sent),
        .total_sent (total_sent),
        .lost       (lost)
    );

    swle_divider #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (lost),
        .divisor  (total_sent),
        .done     (div_done),
        .quotient (quotient)
    );

`ifndef SYNTHESIS
    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside the done state");

    a_reject_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !ok) |=> (fill == $past(fill)))
        else $error("rejected report changed the window fill");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= FILL_W'(WINDOW_BINS))
        else $error("window fill above the ring depth");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_raw_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        raw_rate_reg <= swle_pkg::Q_ONE)
        else $error("raw loss rate above one");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the sliding window loss estimator. A directed table
// of loss reports walks the corner cases (rejects, empty window, clamp limits,
// min above max, stale clamp after a register change), then random reports
// run over several clamp settings. Every result word is compared field by
// field with a typed table word or an in-bench window predictor, under
// random sender bursts and receiver stalls.
// ============================================================================
module tb_top;

    localparam int BINS        = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 80;

    typedef struct packed {
        logic                            accepted;
        logic [swle_pkg::RATE_W-1:0]     raw;
        logic [swle_pkg::RATE_W-1:0]     limited;
        logic [swle_pkg::FILL_OUT_W-1:0] fill;
    } loss_word_t;

    typedef struct packed {
        logic                           cfg_en;
        logic [swle_pkg::CFG_IDX_W-1:0] cfg_idx;
        logic [swle_pkg::RATE_W-1:0]    cfg_val;
        logic [swle_pkg::DATA_W-1:0]    seen;
        logic [swle_pkg::DATA_W-1:0]    sent;
        logic                           typed;
        loss_word_t                     want;
    } report_row_t;

    localparam loss_word_t NO_WORD = '0;
    localparam int         N_ROWS  = 23;

    report_row_t report_rows [N_ROWS] = '{
        '{1'b0, swle_pkg::REG_MIN_LOSS, 17'd0, 32'd5, 32'd0, 1'b1,
          '{1'b0, 17'd0, 17'd0, 6'd0}},
        '{1'b0, swle_pkg::REG_MIN_LOSS, 17'd0, 32'd0, 32'd0, 1'b1,
          '{1'b0, 17'd0, 17'd0, 6'd0}},
        '{1'b0, swle_pkg::REG_MIN_LOSS, 17'd0, 32'hFFFFFFFF, 32'hFFFFFFFE, 1'b1,
          '{1'b0, 17'd0, 17'd0, 6'd0}},
        '{1'b1, swle_pkg::REG_MIN_LOSS, 17'd12345, 32'd1, 32'd0, 1'b1,
          '{1'b0, 17'd0, 17'd12345, 6'd0}},
        '{1'b1, swle_pkg::REG_MIN_LOSS, swle_pkg::Q_ONE, 32'd2, 32'd1, 1'b1,
          '{1'b0, 17'd0, swle_pkg::Q_ONE, 6'd0}},
        '{1'b1, swle_pkg::REG_MIN_LOSS, 17'd0, 32'd0, 32'd1, 1'b1,
          '{1'b1, swle_pkg::Q_ONE, swle_pkg::Q_ONE, 6'd1}},
        '{1'b0, swle_pkg::REG_MIN_LOSS, 17'd0, 32'd0, 32'hFFFFFFFF, 1'b1,
          '{1'b1, swle_pkg::Q_ONE, swle_pkg::Q_ONE, 6'd2}},
        '{1'b0, swle_pkg::REG_MIN_LOSS, 17'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, NO_WORD},
        '{1'b0, swle_pkg::REG_MIN_LOSS, 17'd0, 32'd1, 32'd1, 1'b0, NO_WORD},
        '{1'b0, swle_pkg::REG_MIN_LOSS, 17'd0, 32'd7, 32'd0, 1'b0, NO_WORD},
        // stale clamp: rejected word after a max change
        '{1'b1, swle_pkg::REG_MAX_LOSS, 17'd0, 32'd9, 32'd3, 1'b0, NO_WORD},
        '{1'b0, swle_pkg::REG_MIN_LOSS, 17'd0, 32'd3, 32'd10, 1'b0, NO_WORD},
        '{1'b0, swle_pkg::REG_MIN_LOSS, 17'd0, 32'd8, 32'd8, 1'b0, NO_WORD},
        // min above max
        '{1'b1, swle_pkg::REG_MIN_LOSS, 17'd40000, 32'd5, 32'd10, 1'b0, NO_WORD},
        '{1'b1, swle_pkg::REG_MAX_LOSS, swle_pkg::Q_ONE, 32'd100, 32'd200, 1'b0, NO_WORD},
        '{1'b1, swle_pkg::REG_MIN_LOSS, 17'd0, 32'h80000000, 32'h80000000, 1'b0, NO_WORD},
        '{1'b0, swle_pkg::REG_MIN_LOSS, 17'd0, 32'hAAAAAAAA, 32'hFFFFFFFF, 1'b0, NO_WORD},
        '{1'b0, swle_pkg::REG_MIN_LOSS, 17'd0, 32'h55555555, 32'h55555556, 1'b0, NO_WORD},
        '{1'b0, swle_pkg::REG_MIN_LOSS, 17'd0, 32'd0, 32'd1, 1'b0, NO_WORD},
        '{1'b0, swle_pkg::REG_MIN_LOSS, 17'd0, 32'd1, 32'd2, 1'b0, NO_WORD},
        '{1'b0, swle_pkg::REG_MIN_LOSS, 17'd0, 32'hFFFFFFFF, 32'd0, 1'b0, NO_WORD},
        '{1'b0, swle_pkg::REG_MIN_LOSS, 17'd0, 32'h12345678, 32'h87654321, 1'b0, NO_WORD},
        '{1'b0, swle_pkg::REG_MIN_LOSS, 17'd0, 32'd0, 32'h0FFFFFFF, 1'b0, NO_WORD}
    };

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_write;
    logic [swle_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [swle_pkg::RATE_W-1:0]     cfg_data;
    logic                            report_valid;
    logic                            report_stall;
    logic [swle_pkg::DATA_W-1:0]     seen_packets;
    logic [swle_pkg::DATA_W-1:0]     sent_packets;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    logic                            accepted;
    logic [swle_pkg::RATE_W-1:0]     raw_loss;
    logic [swle_pkg::RATE_W-1:0]     limited_loss;
    logic [swle_pkg::FILL_OUT_W-1:0] window_fill;

    // typed expectation travels with the word
    logic                  word_typed;
    loss_word_t            word_typed_exp;

    // window predictor state
    logic [swle_pkg::DATA_W-1:0] win_seen [BINS];
    logic [swle_pkg::DATA_W-1:0] win_sent [BINS];
    int                          win_slot = 0;
    int                          win_count = 0;
    logic [63:0]                 sum_seen = '0;
    logic [63:0]                 sum_sent = '0;
    logic [swle_pkg::RATE_W-1:0] rate_raw = '0;
    logic [swle_pkg::RATE_W-1:0] rate_limited = '0;
    logic [swle_pkg::RATE_W-1:0] lim_min = '0;
    logic [swle_pkg::RATE_W-1:0] lim_max = swle_pkg::Q_ONE;

    loss_word_t            pending_words [$];
    int                    error_count = 0;
    int                    words_sent = 0;
    int                    reports_stored = 0;
    int                    words_checked = 0;
    int                    reg_writes = 0;
    int                    cycle_count = 0;
    int                    burst_left = 0;
    int                    stall_seg = 0;
    int                    stall_mode = 0;

    sliding_window_loss_estimator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .seen_packets (seen_packets),
        .sent_packets (sent_packets),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .accepted     (accepted),
        .raw_loss     (raw_loss),
        .limited_loss (limited_loss),
        .window_fill  (window_fill)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [swle_pkg::RATE_W-1:0] clamp_rate(
        input logic [swle_pkg::RATE_W-1:0] r);
        if (r < lim_min)
            return lim_min;
        if (r > lim_max)
            return lim_max;
        return r;
    endfunction

    task automatic fold_report(input logic [swle_pkg::DATA_W-1:0] seen,
                               input logic [swle_pkg::DATA_W-1:0] sent,
                               output loss_word_t w);
        logic        ok;
        logic [63:0] lost;
        logic [63:0] quot;
        ok = (sent != 0) && (seen <= sent);
        if (ok)
        begin
            if (win_count >= BINS)
            begin
                sum_seen = sum_seen - 64'(win_seen[win_slot]);
                sum_sent = sum_sent - 64'(win_sent[win_slot]);
            end
            else
                win_count++;
            win_seen[win_slot] = seen;
            win_sent[win_slot] = sent;
            sum_seen = sum_seen + 64'(seen);
            sum_sent = sum_sent + 64'(sent);
            win_slot = (win_slot == BINS - 1) ? 0 : win_slot + 1;
            lost = sum_sent - sum_seen;
            quot = (lost << 16) / sum_sent;
            if (quot > 64'(swle_pkg::Q_ONE))
                quot = 64'(swle_pkg::Q_ONE);
            rate_raw = quot[swle_pkg::RATE_W-1:0];
            rate_limited = clamp_rate(rate_raw);
        end
        w.accepted = ok;
        w.raw      = rate_raw;
        w.limited  = (win_count == 0) ? lim_min : rate_limited;
        w.fill     = win_count[swle_pkg::FILL_OUT_W-1:0];
    endtask

    always @(posedge clk)
    begin
        loss_word_t w;
        if (rst_n && report_valid && !report_stall)
        begin
            fold_report(seen_packets, sent_packets, w);
            if (w.accepted)
                reports_stored++;
            if (word_typed)
                w = word_typed_exp;
            pending_words.push_back(w);
            words_sent++;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        loss_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_words.size() == 0)
            begin
                $error("result word with no report pending");
                error_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("accepted", 32'(want.accepted), 32'(accepted));
                check_field("raw_loss", 32'(want.raw), 32'(raw_loss));
                check_field("limited_loss", 32'(want.limited), 32'(limited_loss));
                check_field("window_fill", 32'(want.fill), 32'(window_fill));
                words_checked++;
            end
        end
    end

    // receiver stall pattern: segments of random length, each with its own density
    always @(posedge clk)
    begin
        if (stall_seg == 0)
        begin
            stall_seg  = $urandom_range(1, 60);
            stall_mode = $urandom_range(0, 3);
        end
        else
            stall_seg--;
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 3) == 0);
            2:       result_stall <= $urandom_range(0, 1);
            default: result_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // called at a rising edge; returns at the take edge, later if the burst ends
    task automatic push_report(input logic [swle_pkg::DATA_W-1:0] seen,
                               input logic [swle_pkg::DATA_W-1:0] sent,
                               input logic typed, input loss_word_t want);
        report_valid   <= 1'b1;
        seen_packets   <= seen;
        sent_packets   <= sent;
        word_typed     <= typed;
        word_typed_exp <= want;
        do
            @(posedge clk);
        while (report_stall);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            report_valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic set_register(input logic [swle_pkg::CFG_IDX_W-1:0] idx,
                                input logic [swle_pkg::RATE_W-1:0] val);
        report_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == swle_pkg::REG_MIN_LOSS)
            lim_min = val;
        else
            lim_max = val;
        reg_writes++;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        logic [swle_pkg::DATA_W-1:0] s;
        logic [swle_pkg::DATA_W-1:0] t;
        logic [swle_pkg::RATE_W-1:0] mn;
        logic [swle_pkg::RATE_W-1:0] mx;
        int                          kind;

        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = swle_pkg::REG_MIN_LOSS;
        cfg_data       = '0;
        report_valid   = 1'b0;
        seen_packets   = '0;
        sent_packets   = '0;
        word_typed     = 1'b0;
        word_typed_exp = NO_WORD;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
        begin
            if (report_rows[r].cfg_en)
                set_register(report_rows[r].cfg_idx, report_rows[r].cfg_val);
            push_report(report_rows[r].seen, report_rows[r].sent, report_rows[r].typed,
                        report_rows[r].want);
        end

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: begin mn = '0; mx = swle_pkg::Q_ONE; end
                1: begin mn = '0; mx = '0; end
                2: begin mn = swle_pkg::Q_ONE; mx = swle_pkg::Q_ONE; end
                3: begin mn = 17'd2000; mx = 17'd30000; end
                4: begin mn = 17'd50000; mx = 17'd10000; end
                7: begin mn = '0; mx = swle_pkg::Q_ONE; end
                default:
                begin
                    mn = swle_pkg::RATE_W'($urandom_range(0, 65536));
                    mx = swle_pkg::RATE_W'($urandom_range(0, 65536));
                end
            endcase
            set_register(swle_pkg::REG_MIN_LOSS, mn);
            set_register(swle_pkg::REG_MAX_LOSS, mx);
            for (int i = 0; i < 100; i++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 35)
                begin
                    t = $urandom_range(1, 5000);
                    s = t - $urandom_range(0, t >> $urandom_range(0, 6));
                end
                else if (kind < 50)
                begin
                    t = $urandom_range(1, 5000);
                    s = $urandom_range(0, t);
                end
                else if (kind < 66)
                begin
                    t = $urandom;
                    if (t == 0)
                        t = 1;
                    s = swle_pkg::DATA_W'(64'($urandom) % (64'(t) + 64'd1));
                end
                else if (kind < 72)
                begin
                    t = $urandom;
                    if (t == 0)
                        t = 1;
                    s = t;
                end
                else if (kind < 78)
                begin
                    t = $urandom;
                    if (t == 0)
                        t = 1;
                    s = 0;
                end
                else if (kind < 86)
                begin
                    t = 0;
                    s = $urandom;
                end
                else
                begin
                    t = $urandom_range(0, 32'hFFFFFFFE);
                    s = swle_pkg::DATA_W'(64'(t) + 64'd1 +
                                (64'($urandom) % (64'hFFFFFFFF - 64'(t))));
                end
                push_report(s, t, 1'b0, NO_WORD);
            end
        end

        report_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d report words (%0d stored, %0d rejected) over %0d register writes",
                 words_sent, reports_stored, words_sent - reports_stored, reg_writes);
        $display("%0d result words checked, %0d mismatches", words_checked, error_count);
        if (error_count == 0 && pending_words.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/swle_pkg.sv
hw/rtl/swle_ring.sv
hw/rtl/swle_serial_sum.sv
hw/rtl/swle_divider.sv
hw/rtl/sliding_window_loss_estimator.sv
bench/tb_top.sv
